// File: rtl/hlpi_pkg.sv
// Shared constants, types and the sine quarter-wave table for the line pair intersect block.
package hlpi_pkg;

  localparam int ANGLE_FRAC_BITS  = 13;
  localparam int TRIG_TABLE_DEPTH = 1024;

  localparam int RHO_W   = 16;
  localparam int ANGLE_W = 15;
  localparam int COORD_W = 24;

  localparam int OFF_W  = $clog2(TRIG_TABLE_DEPTH);
  localparam int ADDR_W = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int IDX_W  = OFF_W + 2;
  localparam longint unsigned FULL = 4 * TRIG_TABLE_DEPTH;

  localparam longint unsigned PI_Q32      = 64'd13493037705;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned PI_Q =
      (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
  localparam longint unsigned DEN = 2 * PI_Q;
  localparam longint unsigned OFS = FULL * DEN;

  // angle-to-index: floor(n / DEN) by reciprocal multiply plus one correction
  localparam int N_W      = 29;
  localparam int DEN_Q_W  = 16;
  localparam int RECIP_SH = 45;
  localparam int RECIP_W  = 30;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / DEN;
  localparam int QE_W  = 13;
  localparam int REM_W = 17;

  localparam int SINE_W = 31;
  localparam int TRIG_W = 32;
  localparam int PROD_W = 48;
  localparam int MAG_W  = 47;
  localparam int NUM_W  = 48;
  localparam int DIV_W  = 31;
  localparam int QUO_W  = 25;

  localparam int DIV_LAT  = QUO_W + 1;
  localparam int PRE_LAT  = 8;
  localparam int PIPE_LAT = PRE_LAT + DIV_LAT;

  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 15'd804;
  localparam logic [COORD_W-1:0] COORD_MAX     = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] COORD_MIN     = 24'h800000;
  localparam logic [QUO_W-1:0]   MAX_MAG_POS   = 25'd8388607;
  localparam logic [QUO_W-1:0]   MAX_MAG_NEG   = 25'd8388608;

  typedef logic [SINE_W-1:0] sine_tab_t [0:TRIG_TABLE_DEPTH];

  typedef struct packed {
    logic acc;
    logic par;
    logic neg_x;
    logic neg_y;
  } side_t;

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_tab_t sine_table();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
      x = (longint'(i) * HALF_PI_Q30 + (64'd1 << (OFF_W - 1))) >> OFF_W;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = udiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      tab[i] = sum[SINE_W-1:0];
    end
    return tab;
  endfunction

endpackage

// File: rtl/hlpi_angle_idx.sv
// Two-stage angle to table index conversion (reciprocal divide by the step size).
module hlpi_angle_idx (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hlpi_pkg::N_W-1:0]     n_i,
  output logic [hlpi_pkg::IDX_W-1:0]   idx_o
);

  localparam int PW = hlpi_pkg::N_W + hlpi_pkg::RECIP_W;
  localparam logic [hlpi_pkg::RECIP_W-1:0] RECIP_V = hlpi_pkg::RECIP[hlpi_pkg::RECIP_W-1:0];
  localparam logic [hlpi_pkg::DEN_Q_W-1:0] DEN_V = hlpi_pkg::DEN[hlpi_pkg::DEN_Q_W-1:0];

  logic [PW-1:0]                   prod;
  logic [hlpi_pkg::QE_W-1:0]       qe_d, qe_q;
  logic [hlpi_pkg::N_W-1:0]        n_q;
  logic [hlpi_pkg::N_W-1:0]        qd;
  logic [hlpi_pkg::N_W-1:0]        rem_full;
  logic [hlpi_pkg::REM_W-1:0]      rem;
  logic [hlpi_pkg::QE_W-1:0]       q;

  assign prod = PW'(n_i) * PW'(RECIP_V);
  assign qe_d = prod[hlpi_pkg::RECIP_SH +: hlpi_pkg::QE_W];

  assign qd       = hlpi_pkg::N_W'(qe_q) * hlpi_pkg::N_W'(DEN_V);
  assign rem_full = n_q - qd;
  assign rem      = rem_full[hlpi_pkg::REM_W-1:0];
  assign q        = qe_q + hlpi_pkg::QE_W'(rem >= hlpi_pkg::REM_W'(DEN_V));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe_q  <= qe_d;
      n_q   <= n_i;
      idx_o <= q[hlpi_pkg::IDX_W-1:0];
    end
  end

endmodule

// File: rtl/hlpi_sine_lut.sv
// Quarter-wave sine lookup: index to signed Q30 sine, two register stages.
module hlpi_sine_lut (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [hlpi_pkg::IDX_W-1:0]         idx_i,
  output logic signed [hlpi_pkg::TRIG_W-1:0] sine_o
);

  localparam hlpi_pkg::sine_tab_t TAB = hlpi_pkg::sine_table();
  localparam logic [hlpi_pkg::ADDR_W-1:0] DEPTH_V =
      hlpi_pkg::ADDR_W'(hlpi_pkg::TRIG_TABLE_DEPTH);

  logic [1:0]                      quad;
  logic [hlpi_pkg::ADDR_W-1:0]     off;
  logic [hlpi_pkg::ADDR_W-1:0]     addr;
  logic [hlpi_pkg::SINE_W-1:0]     mag_q;
  logic                            neg_q;

  assign quad = idx_i[hlpi_pkg::IDX_W-1 -: 2];
  assign off  = hlpi_pkg::ADDR_W'(idx_i[hlpi_pkg::OFF_W-1:0]);
  assign addr = quad[0] ? DEPTH_V - off : off;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= TAB[addr];
      neg_q  <= quad[1];
      sine_o <= neg_q ? -signed'(hlpi_pkg::TRIG_W'(mag_q)) : signed'(hlpi_pkg::TRIG_W'(mag_q));
    end
  end

endmodule

// File: rtl/hlpi_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module hlpi_divider (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hlpi_pkg::NUM_W-1:0]    num_i,
  input  logic [hlpi_pkg::DIV_W-1:0]    den_i,
  output logic [hlpi_pkg::QUO_W-1:0]    quo_o,
  output logic                          ovf_o
);

  localparam int QW = hlpi_pkg::QUO_W;
  localparam int DW = hlpi_pkg::DIV_W;
  localparam int NW = hlpi_pkg::NUM_W;

  logic [DW-1:0] rem_q [0:QW];
  logic [QW-1:0] lo_q  [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic          ovf_q [0:QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(num_i[NW-1:QW]);
      lo_q[0]  <= num_i[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= DW'(num_i[NW-1:QW]) >= den_i;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_q[i], lo_q[i][QW-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign ge    = trial >= {1'b0, den_q[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo_q[i+1]  <= {lo_q[i][QW-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][QW-2:0], ge};
        den_q[i+1] <= den_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// File: rtl/hough_line_pair_intersect_top.sv
// Top level: intersection of two polar lines, pipelined at one pair per cycle while the output is not stalled.
//
// Input stream s_axis carries one line pair per beat; the result stream m_axis
// returns one beat per pair, in order. cfg_* writes the minimum angle register;
// cfg_ready_o is always high and writes are meant for idle periods.
// From input beat to output valid a pair passes 8 stages of angle
// indexing, sine lookup, products and magnitudes, then 25 quotient stages and
// the divider input register, then the output register.
// Throughput is one pair per cycle unless stalled; stages are register slices
// with no feedback, so the divider pipeline sets the latency, not the rate.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; s_axis_tready_o then drops until the skid
// drains, and the whole pipeline holds without losing or repeating beats.
// Reset clears all valid bits and loads the minimum angle with pi/32.
module hough_line_pair_intersect_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_rho, first_theta, second_rho, second_theta, zero pad
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cross_x, cross_y
  output logic [47:0] m_axis_tdata_o,
  // accepted, parallel, saturated
  output logic [2:0]  m_axis_tuser_o
);

  localparam int RW = hlpi_pkg::RHO_W;
  localparam int AW = hlpi_pkg::ANGLE_W;
  localparam int CW = hlpi_pkg::COORD_W;
  localparam int TW = hlpi_pkg::TRIG_W;
  localparam int PW = hlpi_pkg::PROD_W;
  localparam int NW = hlpi_pkg::N_W;
  localparam int DL = hlpi_pkg::DIV_LAT;
  localparam int PL = hlpi_pkg::PIPE_LAT;

  localparam logic [AW:0]   PI_V  = (AW + 1)'(hlpi_pkg::PI_Q);
  localparam logic [31:0]   PI_32 = 32'(hlpi_pkg::PI_Q);
  localparam logic [31:0]   OFS_32 = 32'(hlpi_pkg::OFS);
  localparam logic [hlpi_pkg::IDX_W-1:0] QTR_V =
      hlpi_pkg::IDX_W'(hlpi_pkg::TRIG_TABLE_DEPTH);

  logic en;
  logic [AW-1:0] min_angle_q;
  logic [PL-1:0] v_q;

  // input fields
  logic signed [RW-1:0] in_r1, in_r2;
  logic [AW-1:0]        in_t1, in_t2;
  logic [AW:0]          a1, a2, diff;
  logic                 acc_d;
  logic signed [31:0]   t1_s, t2_s, n1_s, n2_s, nd_s;

  logic signed [RW-1:0] r1_q [0:4];
  logic signed [RW-1:0] r2_q [0:4];
  logic                 acc_q [0:6];
  logic [NW-1:0]        n1_q, n2_q, nd_q;

  logic [hlpi_pkg::IDX_W-1:0] i1, i2, id;
  logic signed [TW-1:0] s1, s2, c1, c2, det;

  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [TW-1:0] det6_q, det7_q;
  logic signed [PW-1:0] nx_q, ny_q;

  logic [hlpi_pkg::MAG_W-1:0] magx, magy;
  logic [TW-1:0]              md_full;
  logic [hlpi_pkg::DIV_W-1:0] md;
  logic [hlpi_pkg::NUM_W-1:0] numx_q, numy_q;
  logic [hlpi_pkg::DIV_W-1:0] md_q;
  hlpi_pkg::side_t            side8_q;
  hlpi_pkg::side_t            side_q [0:DL-1];

  logic [hlpi_pkg::QUO_W-1:0] qx, qy;
  logic                       ovx, ovy;

  logic [CW-1:0] res_x, res_y;
  logic          big_x, big_y;
  logic [2:0]    res_user;
  logic [47:0]   res_data;

  logic          out_v_q, skid_v_q;
  logic [2:0]    out_user_q, skid_user_q;
  logic [47:0]   out_data_q, skid_data_q;

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q <= hlpi_pkg::MIN_ANGLE_RST;
    end else if (cfg_valid_i) begin
      min_angle_q <= cfg_data_i;
    end
  end

  // acceptance test and angle numerators
  assign in_r1 = signed'(s_axis_tdata_i[15:0]);
  assign in_t1 = s_axis_tdata_i[30:16];
  assign in_r2 = signed'(s_axis_tdata_i[46:31]);
  assign in_t2 = s_axis_tdata_i[61:47];

  assign a1    = (in_t1 < min_angle_q) ? {1'b0, in_t1} + PI_V : {1'b0, in_t1};
  assign a2    = (in_t2 < min_angle_q) ? {1'b0, in_t2} + PI_V : {1'b0, in_t2};
  assign diff  = (a1 > a2) ? a1 - a2 : a2 - a1;
  assign acc_d = diff > {1'b0, min_angle_q};

  assign t1_s = signed'({17'd0, in_t1});
  assign t2_s = signed'({17'd0, in_t2});
  assign n1_s = (t1_s <<< hlpi_pkg::IDX_W) + signed'(PI_32) + signed'(OFS_32);
  assign n2_s = (t2_s <<< hlpi_pkg::IDX_W) + signed'(PI_32) + signed'(OFS_32);
  assign nd_s = ((t2_s - t1_s) <<< hlpi_pkg::IDX_W) + signed'(PI_32) + signed'(OFS_32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q[0]  <= in_r1;
      r2_q[0]  <= in_r2;
      acc_q[0] <= acc_d;
      n1_q     <= n1_s[NW-1:0];
      n2_q     <= n2_s[NW-1:0];
      nd_q     <= nd_s[NW-1:0];
      for (int k = 1; k < 5; k++) begin
        r1_q[k] <= r1_q[k-1];
        r2_q[k] <= r2_q[k-1];
      end
      for (int k = 1; k < 7; k++) begin
        acc_q[k] <= acc_q[k-1];
      end
    end
  end

  hlpi_angle_idx u_idx_1 (.clk_i(clk_i), .en_i(en), .n_i(n1_q), .idx_o(i1));
  hlpi_angle_idx u_idx_2 (.clk_i(clk_i), .en_i(en), .n_i(n2_q), .idx_o(i2));
  hlpi_angle_idx u_idx_d (.clk_i(clk_i), .en_i(en), .n_i(nd_q), .idx_o(id));

  hlpi_sine_lut u_sin_1 (.clk_i(clk_i), .en_i(en), .idx_i(i1),         .sine_o(s1));
  hlpi_sine_lut u_cos_1 (.clk_i(clk_i), .en_i(en), .idx_i(i1 + QTR_V), .sine_o(c1));
  hlpi_sine_lut u_sin_2 (.clk_i(clk_i), .en_i(en), .idx_i(i2),         .sine_o(s2));
  hlpi_sine_lut u_cos_2 (.clk_i(clk_i), .en_i(en), .idx_i(i2 + QTR_V), .sine_o(c2));
  hlpi_sine_lut u_det   (.clk_i(clk_i), .en_i(en), .idx_i(id),         .sine_o(det));

  // products, numerators, magnitudes
  assign magx    = nx_q[PW-1] ? hlpi_pkg::MAG_W'(-nx_q) : hlpi_pkg::MAG_W'(nx_q);
  assign magy    = ny_q[PW-1] ? hlpi_pkg::MAG_W'(-ny_q) : hlpi_pkg::MAG_W'(ny_q);
  assign md_full = det7_q[TW-1] ? TW'(-det7_q) : TW'(det7_q);
  assign md      = md_full[hlpi_pkg::DIV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q   <= PW'(r1_q[4]) * PW'(s2);
      pb_q   <= PW'(r2_q[4]) * PW'(s1);
      pc_q   <= PW'(r2_q[4]) * PW'(c1);
      pd_q   <= PW'(r1_q[4]) * PW'(c2);
      det6_q <= det;
      nx_q   <= pa_q - pb_q;
      ny_q   <= pc_q - pd_q;
      det7_q <= det6_q;
      numx_q <= hlpi_pkg::NUM_W'(magx) + hlpi_pkg::NUM_W'(md >> 1);
      numy_q <= hlpi_pkg::NUM_W'(magy) + hlpi_pkg::NUM_W'(md >> 1);
      md_q   <= md;
      side8_q.acc   <= acc_q[6];
      side8_q.par   <= det7_q == '0;
      side8_q.neg_x <= nx_q[PW-1] ^ det7_q[TW-1];
      side8_q.neg_y <= ny_q[PW-1] ^ det7_q[TW-1];
      side_q[0] <= side8_q;
      for (int k = 1; k < DL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  hlpi_divider u_div_x (.clk_i(clk_i), .en_i(en), .num_i(numx_q), .den_i(md_q),
                        .quo_o(qx), .ovf_o(ovx));
  hlpi_divider u_div_y (.clk_i(clk_i), .en_i(en), .num_i(numy_q), .den_i(md_q),
                        .quo_o(qy), .ovf_o(ovy));

  // sign, clip, gating
  always_comb begin
    big_x = ovx | (side_q[DL-1].neg_x ? qx > hlpi_pkg::MAX_MAG_NEG
                                      : qx > hlpi_pkg::MAX_MAG_POS);
    big_y = ovy | (side_q[DL-1].neg_y ? qy > hlpi_pkg::MAX_MAG_NEG
                                      : qy > hlpi_pkg::MAX_MAG_POS);
    if (big_x) begin
      res_x = side_q[DL-1].neg_x ? hlpi_pkg::COORD_MIN : hlpi_pkg::COORD_MAX;
    end else begin
      res_x = side_q[DL-1].neg_x ? -qx[CW-1:0] : qx[CW-1:0];
    end
    if (big_y) begin
      res_y = side_q[DL-1].neg_y ? hlpi_pkg::COORD_MIN : hlpi_pkg::COORD_MAX;
    end else begin
      res_y = side_q[DL-1].neg_y ? -qy[CW-1:0] : qy[CW-1:0];
    end
    if (!side_q[DL-1].acc) begin
      res_user = 3'b000;
      res_data = '0;
    end else if (side_q[DL-1].par) begin
      res_user = 3'b011;
      res_data = '0;
    end else begin
      res_user = {big_x | big_y, 1'b0, 1'b1};
      res_data = {res_y, res_x};
    end
  end

  // valid chain and output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      v_q <= {v_q[PL-2:0], s_axis_tvalid_i};
      if (out_v_q && !m_axis_tready_i) begin
        skid_v_q <= v_q[PL-1];
      end else begin
        out_v_q <= v_q[PL-1];
      end
    end else if (m_axis_tready_i) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_v_q && !m_axis_tready_i) begin
        skid_user_q <= res_user;
        skid_data_q <= res_data;
      end else begin
        out_user_q <= res_user;
        out_data_q <= res_data;
      end
    end else if (m_axis_tready_i) begin
      out_user_q <= skid_user_q;
      out_data_q <= skid_data_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while output is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready_i))
    else $error("skid filled without an output stall");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_user_q[0]) |-> (out_user_q[2:1] == 2'b00 && out_data_q == '0))
    else $error("rejected pair carries nonzero result");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_user_q[1]) |-> (!out_user_q[2] && out_data_q == '0))
    else $error("parallel pair carries coordinates or saturation");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_user_q[2]) |->
      (out_data_q[23:0] == hlpi_pkg::COORD_MAX || out_data_q[23:0] == hlpi_pkg::COORD_MIN ||
       out_data_q[47:24] == hlpi_pkg::COORD_MAX || out_data_q[47:24] == hlpi_pkg::COORD_MIN))
    else $error("saturated flag without a clipped coordinate");
`endif

endmodule
